// ===== rtl/core/launcher_interlock_sequencer_assert.svh =====
// Assertion macros for the launcher interlock sequencer checkers.
// Depends on nothing; included by the checker file only.
`ifndef LAUNCHER_INTERLOCK_SEQUENCER_ASSERT_SVH
`define LAUNCHER_INTERLOCK_SEQUENCER_ASSERT_SVH

// An implication checked in the same cycle, disabled during reset.
`define LIS_ASSERT_NOW(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// An implication whose consequent is checked in the next cycle, disabled during reset.
`define LIS_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

// ===== rtl/core/lis_pkg.sv =====
// Shared constants for the launcher interlock sequencer.
// Depends on nothing; used by the top level and its checker.
`default_nettype none

package lis_pkg;

  // Default position width of the axis fields.
  localparam int POSITION_BITS_DEFAULT = 16;

  // Deadband register width and its value after reset.
  localparam int DEADBAND_BITS = 10;
  localparam logic [DEADBAND_BITS-1:0] DEADBAND_RESET = 10'd10;

  // Mode codes.
  localparam int MODE_BITS = 3;
  localparam logic [MODE_BITS-1:0] MODE_IDLE       = 3'd0;
  localparam logic [MODE_BITS-1:0] MODE_ARMED      = 3'd1;
  localparam logic [MODE_BITS-1:0] MODE_AIMING     = 3'd2;
  localparam logic [MODE_BITS-1:0] MODE_DRAWING    = 3'd3;
  localparam logic [MODE_BITS-1:0] MODE_DRAWN      = 3'd4;
  localparam logic [MODE_BITS-1:0] MODE_RETRACTING = 3'd5;
  localparam logic [MODE_BITS-1:0] MODE_FIRING     = 3'd6;
  localparam logic [MODE_BITS-1:0] MODE_FIRED      = 3'd7;

  // Result bus width and field positions.
  localparam int OUT_W         = 8;
  localparam int OUT_MOVING    = 3;
  localparam int OUT_DRAW      = 4;
  localparam int OUT_RETRACT   = 5;
  localparam int OUT_FIRE      = 6;

endpackage

`default_nettype wire

// ===== rtl/core/launcher_interlock_sequencer.sv =====
// Launcher interlock sequencer: eight-state aim, draw, fire and retract control.
// Depends on lis_pkg for mode codes, field positions and reset constants.
//
// Path: an accepted input transaction goes through the input register, then the
// state update and result register.
// Throughput: one transaction per cycle while the result is not stalled; the state update is the loop.
// Reset (rst, synchronous): mode idle, motion flag and request latches clear,
// deadband back to 10, both pipeline stages empty.
`default_nettype none

module launcher_interlock_sequencer #(
  parameter int POSITION_BITS = lis_pkg::POSITION_BITS_DEFAULT,
  localparam int IN_W = ((4 * POSITION_BITS + 8 + 7) / 8) * 8
) (
  input  wire logic                            clk,
  input  wire logic                            rst,
  // Deadband register write.
  input  wire logic                            cfg_we,
  input  wire logic [lis_pkg::DEADBAND_BITS-1:0] cfg_wdata,
  // Tick input. tdata from bit 0: arming_chain, front_clear, rear_clear,
  // moving_write, moving_value, x_position, y_position, x_target, y_target,
  // draw_request, retract_request, fire_request, zero fill.
  input  wire logic                            s_tvalid,
  output logic                                 s_tready,
  input  wire logic [IN_W-1:0]                 s_tdata,
  // Result. tdata from bit 0: mode (3), moving, draw_pending,
  // retract_pending, fire_pending, zero fill.
  output logic                                 m_tvalid,
  input  wire logic                            m_tready,
  output logic [lis_pkg::OUT_W-1:0]            m_tdata
);

  localparam int P  = POSITION_BITS;
  localparam int CW = POSITION_BITS + 12;

  // Field offsets within the input word.
  localparam int XP_LSB  = 5;
  localparam int YP_LSB  = 5 + P;
  localparam int XT_LSB  = 5 + 2 * P;
  localparam int YT_LSB  = 5 + 3 * P;
  localparam int DRQ_BIT = 5 + 4 * P;
  localparam int RRQ_BIT = 6 + 4 * P;
  localparam int FRQ_BIT = 7 + 4 * P;

  logic [lis_pkg::DEADBAND_BITS-1:0] deadband;
  logic                              in_valid;
  logic [IN_W-1:0]                   in_data;
  logic                              advance;

  logic [lis_pkg::MODE_BITS-1:0] mode;
  logic [lis_pkg::MODE_BITS-1:0] mode_next;
  logic moving, moving_next;
  logic draw_latch, draw_latch_next;
  logic retract_latch, retract_latch_next;
  logic fire_latch, fire_latch_next;

  logic chain, fclear, rclear;
  logic moving_w, none_pending;
  logic signed [P-1:0]  x_pos, y_pos, x_tgt, y_tgt;
  logic signed [CW-1:0] x_diff, y_diff, dband;
  logic off_target;

  // Configuration register.
  always_ff @(posedge clk) begin
    if (rst) begin
      deadband <= lis_pkg::DEADBAND_RESET;
    end else if (cfg_we) begin
      deadband <= cfg_wdata;
    end
  end

  // Handshake: the input stage moves on whenever the result register is free
  // or being emptied this cycle.
  assign advance  = in_valid && (!m_tvalid || m_tready);
  assign s_tready = !in_valid || advance;

  // Input register.
  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (s_tready) begin
      in_valid <= s_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (s_tready && s_tvalid) begin
      in_data <= s_tdata;
    end
  end

  // Field extraction.
  assign chain  = in_data[0];
  assign fclear = in_data[1];
  assign rclear = in_data[2];
  assign x_pos  = signed'(in_data[XP_LSB +: P]);
  assign y_pos  = signed'(in_data[YP_LSB +: P]);
  assign x_tgt  = signed'(in_data[XT_LSB +: P]);
  assign y_tgt  = signed'(in_data[YT_LSB +: P]);

  // Off-target test on sign-extended differences, wide enough never to overflow.
  assign x_diff = CW'(x_pos) - CW'(x_tgt);
  assign y_diff = CW'(y_pos) - CW'(y_tgt);
  assign dband  = signed'(CW'(deadband));
  assign off_target = (x_diff > dband) || (x_diff < -dband) ||
                      (y_diff > dband) || (y_diff < -dband);

  // Motion write, then request latching with draw over retract over fire.
  assign moving_w     = in_data[3] ? in_data[4] : moving;
  assign none_pending = !draw_latch && !retract_latch && !fire_latch;

  // One transition of the sequencer per tick.
  always_comb begin
    mode_next          = mode;
    moving_next        = moving_w;
    draw_latch_next    = draw_latch || (none_pending && in_data[DRQ_BIT]);
    retract_latch_next = retract_latch ||
                         (none_pending && !in_data[DRQ_BIT] && in_data[RRQ_BIT]);
    fire_latch_next    = fire_latch ||
                         (none_pending && !in_data[DRQ_BIT] && !in_data[RRQ_BIT] &&
                          in_data[FRQ_BIT]);
    unique case (mode)
      lis_pkg::MODE_IDLE: begin
        if (chain) begin
          mode_next = lis_pkg::MODE_ARMED;
        end else if (!moving_w && off_target) begin
          moving_next = 1'b1;
          mode_next   = lis_pkg::MODE_AIMING;
        end
      end
      lis_pkg::MODE_ARMED: begin
        if (!chain) begin
          mode_next = lis_pkg::MODE_IDLE;
        end else if (!moving_w && off_target) begin
          moving_next = 1'b1;
          mode_next   = lis_pkg::MODE_AIMING;
        end else if (!fclear && rclear && draw_latch_next) begin
          draw_latch_next = 1'b0;
          moving_next     = 1'b1;
          mode_next       = lis_pkg::MODE_DRAWING;
        end
      end
      lis_pkg::MODE_AIMING: begin
        if (!moving_w) begin
          mode_next = lis_pkg::MODE_IDLE;
        end
      end
      lis_pkg::MODE_DRAWING: begin
        if (!fclear && !rclear && !moving_w) begin
          mode_next = lis_pkg::MODE_DRAWN;
        end
      end
      lis_pkg::MODE_DRAWN: begin
        if (chain && retract_latch_next) begin
          moving_next        = 1'b1;
          retract_latch_next = 1'b0;
          mode_next          = lis_pkg::MODE_RETRACTING;
        end else if (chain && !rclear && !fclear && fire_latch_next) begin
          fire_latch_next = 1'b0;
          mode_next       = lis_pkg::MODE_FIRING;
        end
      end
      lis_pkg::MODE_RETRACTING: begin
        if (!moving_w && rclear) begin
          mode_next = lis_pkg::MODE_ARMED;
        end
      end
      lis_pkg::MODE_FIRING: begin
        if (rclear && fclear) begin
          mode_next = lis_pkg::MODE_FIRED;
        end
      end
      lis_pkg::MODE_FIRED: begin
        moving_next = 1'b1;
        mode_next   = lis_pkg::MODE_RETRACTING;
      end
      default: begin
        mode_next = mode;
      end
    endcase
  end

  // Sequencer state, updated once per tick.
  always_ff @(posedge clk) begin
    if (rst) begin
      mode          <= lis_pkg::MODE_IDLE;
      moving        <= 1'b0;
      draw_latch    <= 1'b0;
      retract_latch <= 1'b0;
      fire_latch    <= 1'b0;
    end else if (advance) begin
      mode          <= mode_next;
      moving        <= moving_next;
      draw_latch    <= draw_latch_next;
      retract_latch <= retract_latch_next;
      fire_latch    <= fire_latch_next;
    end
  end

  // Result register.
  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (advance) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      m_tdata <= {1'b0, fire_latch_next, retract_latch_next, draw_latch_next,
                  moving_next, mode_next};
    end
  end

endmodule

`default_nettype wire

// ===== rtl/core/lis_checker.sv =====
// Port-level checker for the launcher interlock sequencer, with its bind.
// Depends on lis_pkg and launcher_interlock_sequencer_assert.svh.
`default_nettype none

`include "launcher_interlock_sequencer_assert.svh"

module lis_checker (
  input wire logic                         clk,
  input wire logic                         rst,
  input wire logic                         s_tready,
  input wire logic                         m_tvalid,
  input wire logic                         m_tready,
  input wire logic [lis_pkg::OUT_W-1:0]    m_tdata
);

  // A stalled result holds its value.
  `LIS_ASSERT_NEXT(a_result_hold, clk, rst, m_tvalid && !m_tready, m_tvalid && $stable(m_tdata), "result changed while stalled")

  // At most one request is ever pending.
  `LIS_ASSERT_NOW(a_one_pending, clk, rst, m_tvalid, $onehot0(m_tdata[lis_pkg::OUT_FIRE:lis_pkg::OUT_DRAW]), "more than one request pending")

  // An empty result register never holds back the input side.
  `LIS_ASSERT_NOW(a_ready_when_empty, clk, rst, !m_tvalid, s_tready, "input stalled with no result waiting")

  // No result is offered straight after reset.
  `LIS_ASSERT_NOW(a_empty_after_reset, clk, rst, $past(rst), !m_tvalid, "result valid straight after reset")

endmodule

bind launcher_interlock_sequencer lis_checker u_lis_checker (
  .clk      (clk),
  .rst      (rst),
  .s_tready (s_tready),
  .m_tvalid (m_tvalid),
  .m_tready (m_tready),
  .m_tdata  (m_tdata)
);

`default_nettype wire
